// File: rtl/core/hslp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP status line parser package
// Shared transaction types, outcome codes and the version prefix table.
// ----------------------------------------------------------------------------
package hslp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hslp_in_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic       version_minor;
    logic [9:0] resp_code;
    logic [7:0] phrase_length;
    logic [8:0] line_length;
  } hslp_out_t;

  localparam logic [2:0] OutcomeOk        = 3'd0;
  localparam logic [2:0] OutcomeBadVer    = 3'd1;
  localparam logic [2:0] OutcomeBadSep    = 3'd2;
  localparam logic [2:0] OutcomeBadCode   = 3'd3;
  localparam logic [2:0] OutcomeBadPhrase = 3'd4;
  localparam logic [2:0] OutcomeTrunc     = 3'd5;
  localparam logic [2:0] OutcomeTooLong   = 3'd6;

  // Fixed line offsets
  localparam logic [8:0] LenSep1   = 9'd8;
  localparam logic [8:0] LenCode   = 9'd9;
  localparam logic [8:0] LenSep2   = 9'd12;
  localparam logic [8:0] LenPhrase = 9'd13;
  localparam logic [8:0] LenCr     = 9'd14;
  localparam logic [8:0] LenOkBase = 9'd15;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPrMin = 8'h21;
  localparam logic [7:0] CharPrMax = 8'h7E;

  // "HTTP/1." byte at a given position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/http_status_line_parser_core.sv
// ----------------------------------------------------------------------------
// HTTP status line parser core
// Byte-serial checker for an HTTP/1.x status line with one result per line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one buffer byte per
//   transaction, with last_byte marking the buffer's final byte.
//   Output channel (out_valid_o/out_ready_i/out_data_o) carries at most one
//   result per line: at the LF (ok), the first failing byte or a truncating last byte.
// Timing:
//   A byte sits in the input register; the parse FSM then updates from it and,
//   if the byte ends or fails the line, loads the result register. One byte
//   per cycle is sustained while no result is stalled at the output; the FSM
//   update in the single parse stage sets that rate.
// Stall:
//   While a result waits in the output register and the receiver holds
//   out_ready_i low, the parse stage holds its byte, whether or not that byte
//   gives a result, and the input stops once the input register is full.
// Reset:
//   Both registers empty, parser armed for a new line. After a result, bytes
//   are dropped up to the last byte, which re-arms the parser.
// ----------------------------------------------------------------------------
module http_status_line_parser_core #(
  parameter int PHRASE_MAX_LEN = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hslp_pkg::hslp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hslp_pkg::hslp_out_t out_data_o
);
  import hslp_pkg::*;

  localparam int PhraseLimInt = (PHRASE_MAX_LEN < 255) ? PHRASE_MAX_LEN : 255;
  localparam logic [7:0] PhraseLimit = 8'(PhraseLimInt);

  localparam logic [2:0] PhVersion = 3'd0;
  localparam logic [2:0] PhSep1    = 3'd1;
  localparam logic [2:0] PhCode    = 3'd2;
  localparam logic [2:0] PhSep2    = 3'd3;
  localparam logic [2:0] PhPhrase  = 3'd4;
  localparam logic [2:0] PhCr      = 3'd5;

  logic       in_valid_q;
  hslp_in_t   in_q;
  logic       out_valid_q;
  hslp_out_t  out_q, out_d;

  logic [2:0] phase_q, phase_d;
  logic [2:0] pos_q, pos_d;
  logic       minor_q, minor_d;
  logic [9:0] code_q, code_d;
  logic [7:0] phrase_q, phrase_d;
  logic       reported_q, reported_d;

  logic       proc_en;
  logic       emit;

  assign proc_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_en;

  always_comb begin
    logic [7:0] b;
    logic       fail;
    logic [2:0] oc;
    logic [8:0] len;
    logic [9:0] acc;
    logic       is_phrase_char;

    b              = in_q.data_byte;
    fail           = 1'b0;
    oc             = OutcomeOk;
    len            = '0;
    acc            = '0;
    is_phrase_char = (b == CharSpace) || (b == CharTab) ||
                     ((b >= CharPrMin) && (b <= CharPrMax));

    phase_d    = phase_q;
    pos_d      = pos_q;
    minor_d    = minor_q;
    code_d     = code_q;
    phrase_d   = phrase_q;
    reported_d = reported_q;
    emit       = 1'b0;
    out_d      = out_q;

    unique case (phase_q)
      PhVersion: len = {6'd0, pos_q};
      PhSep1:    len = LenSep1;
      PhCode:    len = LenCode + {6'd0, pos_q};
      PhSep2:    len = LenSep2;
      PhPhrase:  len = LenPhrase + {1'b0, phrase_q};
      default:   len = LenCr + {1'b0, phrase_q};
    endcase
    len = len + 9'd1;

    unique case (phase_q)
      PhVersion: begin
        if (pos_q != 3'd7) begin
          if (b != prefix_char(pos_q)) begin
            fail = 1'b1; oc = OutcomeBadVer;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end else if (b == CharZero || b == CharOne) begin
          minor_d = b[0];
          pos_d   = '0;
          phase_d = PhSep1;
        end else begin
          fail = 1'b1; oc = OutcomeBadVer;
        end
      end
      PhSep1: begin
        if (b != CharSpace) begin
          fail = 1'b1; oc = OutcomeBadSep;
        end else begin
          pos_d   = '0;
          phase_d = PhCode;
        end
      end
      PhCode: begin
        if (b < CharZero || b > CharNine) begin
          fail = 1'b1; oc = OutcomeBadCode;
        end else begin
          // acc * 10 as shift-add, wrapped to 10 bits
          acc    = {code_q[6:0], 3'b000} + {code_q[8:0], 1'b0} + {6'd0, b[3:0]};
          code_d = acc;
          pos_d  = pos_q + 3'd1;
          if (pos_q == 3'd2) begin
            if (acc == '0) begin
              fail = 1'b1; oc = OutcomeBadCode;
            end else begin
              pos_d   = '0;
              phase_d = PhSep2;
            end
          end
        end
      end
      PhSep2: begin
        if (b != CharSpace) begin
          fail = 1'b1; oc = OutcomeBadSep;
        end else begin
          phase_d = PhPhrase;
        end
      end
      PhPhrase: begin
        priority if (b == CharCr) begin
          phase_d = PhCr;
        end else if (!is_phrase_char) begin
          fail = 1'b1; oc = OutcomeBadPhrase;
        end else if (phrase_q >= PhraseLimit) begin
          fail = 1'b1; oc = OutcomeTooLong;
        end else begin
          phrase_d = phrase_q + 8'd1;
        end
      end
      default: begin
        fail = 1'b1;
        oc   = (b == CharLf) ? OutcomeOk : OutcomeBadPhrase;
      end
    endcase

    if (proc_en) begin
      if (reported_q) begin
        if (in_q.last_byte) begin
          phase_d = PhVersion; pos_d = '0; minor_d = 1'b0;
          code_d = '0; phrase_d = '0; reported_d = 1'b0;
        end else begin
          phase_d = phase_q; pos_d = pos_q; minor_d = minor_q;
          code_d = code_q; phrase_d = phrase_q;
        end
      end else begin
        if (fail || in_q.last_byte) begin
          emit = 1'b1;
          if (!fail) oc = OutcomeTrunc;
          out_d.outcome       = oc;
          out_d.version_minor = (oc == OutcomeOk) ? minor_d : 1'b0;
          out_d.resp_code     = (oc == OutcomeOk) ? code_d : '0;
          out_d.phrase_length = phrase_d;
          out_d.line_length   = len;
          if (in_q.last_byte) begin
            phase_d = PhVersion; pos_d = '0; minor_d = 1'b0;
            code_d = '0; phrase_d = '0; reported_d = 1'b0;
          end else begin
            reported_d = 1'b1;
          end
        end
      end
    end else begin
      phase_d = phase_q; pos_d = pos_q; minor_d = minor_q;
      code_d = code_q; phrase_d = phrase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhVersion;
      pos_q       <= '0;
      minor_q     <= 1'b0;
      code_q      <= '0;
      phrase_q    <= '0;
      reported_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      minor_q    <= minor_d;
      code_q     <= code_d;
      phrase_q   <= phrase_d;
      reported_q <= reported_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/hslp_checker.sv
// ----------------------------------------------------------------------------
// HTTP status line parser checker
// Port-level assertions on result transactions, bound to the core.
// ----------------------------------------------------------------------------
module hslp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hslp_pkg::hslp_out_t out_data_o
);
  import hslp_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A good line is the prefix, code, two spaces, phrase and CR LF
  a_ok_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OutcomeOk |->
      out_data_o.line_length == LenOkBase + {1'b0, out_data_o.phrase_length}
      && out_data_o.resp_code != '0)
    else $error("ok result with inconsistent length or zero code");

  // Failures carry no version or code
  a_fail_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome != OutcomeOk |->
      out_data_o.resp_code == '0 && !out_data_o.version_minor)
    else $error("failed result carries version or code");

  // Phrase bytes only counted from offset 13 on
  a_phrase_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.phrase_length != '0 |->
      out_data_o.line_length >= LenPhrase + {1'b0, out_data_o.phrase_length})
    else $error("phrase length exceeds line length");

endmodule

bind http_status_line_parser_core hslp_checker u_hslp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: sim/tb_http_status_line_parser_core.sv
// ----------------------------------------------------------------------------
// HTTP status line parser core testbench
// Feeds byte buffers, both directed lines and random well-formed, damaged and
// cut lines, through the parser with bursty input and a stalling receiver.
// A cycle-free model of the parse predicts each result; a scoreboard checks
// every result field in order.
// ----------------------------------------------------------------------------
module tb_http_status_line_parser_core;
  import hslp_pkg::*;

  localparam int          PhraseMaxLen   = 255;
  localparam int          StimBytes      = 1200;
  localparam int          LongHoldCycles = 500;
  localparam int          IdleLimit      = 4000;
  localparam int          DrainCycles    = 8;
  localparam logic [55:0] VersionPrefix  = "HTTP/1.";

  typedef enum logic [2:0] {
    PhVersion, PhSep1, PhCode, PhSep2, PhPhrase, PhCr
  } parse_phase_e;

  class status_line_predictor;
    parse_phase_e phase;
    int           pos;
    logic         minor;
    int           code_acc;
    int           phrase_cnt;
    bit           reported;
    hslp_out_t    pending[$];
    int           errors;
    int           seen[8];

    function new();
      rearm();
      errors = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void rearm();
      phase      = PhVersion;
      pos        = 0;
      minor      = 1'b0;
      code_acc   = 0;
      phrase_cnt = 0;
      reported   = 1'b0;
    endfunction

    function int bytes_so_far();
      case (phase)
        PhVersion: return pos;
        PhSep1:    return LenSep1;
        PhCode:    return LenCode + pos;
        PhSep2:    return LenSep2;
        PhPhrase:  return LenPhrase + phrase_cnt;
        default:   return LenCr + phrase_cnt;
      endcase
    endfunction

    // Advance the parse by one accepted byte; queue the result it causes.
    function void take_byte(hslp_in_t it);
      logic [7:0] b;
      logic [2:0] outc;
      bit         done;
      int         len;
      hslp_out_t  r;
      b    = it.data_byte;
      done = 1'b0;
      outc = OutcomeOk;
      if (reported) begin
        if (it.last_byte) rearm();
        return;
      end
      len = bytes_so_far() + 1;
      case (phase)
        PhVersion: begin
          if (pos < 7) begin
            if (b != VersionPrefix[8*(6-pos) +: 8]) begin
              done = 1'b1;
              outc = OutcomeBadVer;
            end else begin
              pos++;
            end
          end else if (b == CharZero || b == CharOne) begin
            minor = b[0];
            pos   = 0;
            phase = PhSep1;
          end else begin
            done = 1'b1;
            outc = OutcomeBadVer;
          end
        end
        PhSep1: begin
          if (b != CharSpace) begin
            done = 1'b1;
            outc = OutcomeBadSep;
          end else begin
            pos   = 0;
            phase = PhCode;
          end
        end
        PhCode: begin
          if (b < CharZero || b > CharNine) begin
            done = 1'b1;
            outc = OutcomeBadCode;
          end else begin
            code_acc = (code_acc * 10 + int'(b - CharZero)) & 'h3FF;
            pos++;
            if (pos >= 3) begin
              if (code_acc == 0) begin
                done = 1'b1;
                outc = OutcomeBadCode;
              end else begin
                pos   = 0;
                phase = PhSep2;
              end
            end
          end
        end
        PhSep2: begin
          if (b != CharSpace) begin
            done = 1'b1;
            outc = OutcomeBadSep;
          end else begin
            phase = PhPhrase;
          end
        end
        PhPhrase: begin
          if (b == CharCr) begin
            phase = PhCr;
          end else if (!(b == CharSpace || b == CharTab ||
                         (b >= CharPrMin && b <= CharPrMax))) begin
            done = 1'b1;
            outc = OutcomeBadPhrase;
          end else if (phrase_cnt >= PhraseMaxLen || phrase_cnt >= 255) begin
            done = 1'b1;
            outc = OutcomeTooLong;
          end else begin
            phrase_cnt++;
          end
        end
        default: begin
          done = 1'b1;
          outc = (b == CharLf) ? OutcomeOk : OutcomeBadPhrase;
        end
      endcase
      if (!done) begin
        if (!it.last_byte) return;
        outc = OutcomeTrunc;
      end
      r.outcome       = outc;
      r.version_minor = (outc == OutcomeOk) ? minor : 1'b0;
      r.resp_code     = (outc == OutcomeOk) ? 10'(code_acc) : 10'd0;
      r.phrase_length = 8'(phrase_cnt);
      r.line_length   = 9'(len);
      pending.push_back(r);
      if (it.last_byte) rearm();
      else reported = 1'b1;
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(hslp_out_t act);
      hslp_out_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: outcome %0d, line_length %0d",
               act.outcome, act.line_length);
        errors++;
        return;
      end
      e = pending.pop_front();
      seen[e.outcome]++;
      compare_field("outcome", e.outcome, act.outcome);
      compare_field("version_minor", e.version_minor, act.version_minor);
      compare_field("resp_code", e.resp_code, act.resp_code);
      compare_field("phrase_length", e.phrase_length, act.phrase_length);
      compare_field("line_length", e.line_length, act.line_length);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  hslp_in_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  hslp_out_t out_data;

  status_line_predictor model;
  logic [7:0] line_bytes[$];
  int         items_sent  = 0;
  int         buffers     = 0;
  int         burst_left  = 0;
  int         idle_count  = 0;
  bit         hold_req    = 1'b0;

  http_status_line_parser_core #(
    .PHRASE_MAX_LEN(PhraseMaxLen)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #10 clk = ~clk;

  // Observe both channels; the watchdog trips on a long stretch with no transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) model.take_byte(in_data);
      if (out_valid && out_ready) model.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count = 0;
      else idle_count++;
      if (idle_count >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: ready follows a random 32-bit pattern, refreshed once it is used up.
  initial begin : receiver
    logic [31:0] pat;
    int          k;
    k = 0;
    pat = '1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end
      if (k == 0) begin
        k = 32;
        case ($urandom_range(0, 3))
          0:       pat = '1;
          1:       pat = $urandom;
          default: pat = $urandom | $urandom;
        endcase
      end
      k--;
      out_ready <= pat[k];
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: lst};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
    line_bytes.delete();
    buffers++;
  endtask

  function automatic void push_byte(logic [7:0] b);
    line_bytes.push_back(b);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  function automatic void push_crlf();
    push_byte(CharCr);
    push_byte(CharLf);
  endfunction

  function automatic logic [7:0] phrase_char();
    int r;
    r = $urandom_range(31, 126);
    return (r == 31) ? CharTab : 8'(r);
  endfunction

  function automatic void put_line(bit minor1, int code, int plen);
    push_str("HTTP/1.");
    push_byte(minor1 ? CharOne : CharZero);
    push_byte(CharSpace);
    push_byte(CharZero + 8'(code / 100));
    push_byte(CharZero + 8'((code / 10) % 10));
    push_byte(CharZero + 8'(code % 10));
    push_byte(CharSpace);
    repeat (plen) push_byte(phrase_char());
    push_crlf();
  endfunction

  function automatic int pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 6) return 999;
    if (r < 9) return 1;
    return $urandom_range(1, 999);
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 29) == 0) return $urandom_range(250, 258);
    return $urandom_range(0, 24);
  endfunction

  task automatic run_directed();
    // LF flagged last: the result byte also re-arms
    push_str("HTTP/1.1 200 OK");
    push_crlf();
    send_buffer();
    // empty phrase, top code, tail bytes dropped
    push_str("HTTP/1.0 999 ");
    push_crlf();
    push_str("xyz");
    send_buffer();
    // phrase set edges
    push_str("HTTP/1.1 100 ");
    push_byte(CharTab);
    push_byte(CharPrMin);
    push_byte(CharPrMax);
    push_byte(CharSpace);
    push_crlf();
    send_buffer();
    push_str("HTTX/1.1 200 OK");
    push_crlf();
    send_buffer();
    push_str("HTTP/1.2 200 OK");
    push_crlf();
    send_buffer();
    push_str("HTTP/1.1-200");
    send_buffer();
    push_str("HTTP/1.1 /");
    send_buffer();
    push_str("HTTP/1.1 20:");
    send_buffer();
    // all-zero code
    push_str("HTTP/1.1 000 OK");
    push_crlf();
    send_buffer();
    push_str("HTTP/1.1 404");
    push_byte(CharTab);
    push_str("Not");
    send_buffer();
    push_str("HTTP/1.1 200 A");
    push_byte(8'h7F);
    push_str("BC");
    send_buffer();
    push_str("HTTP/1.1 200 A");
    push_byte(8'h08);
    send_buffer();
    push_str("HTTP/1.1 200 OK");
    push_byte(CharCr);
    push_str("X");
    send_buffer();
    push_str("HTTP/1.1 200 OK");
    push_byte(CharLf);
    send_buffer();
    // cut in the phrase
    push_str("HTTP/1.1 201 Cre");
    send_buffer();
    push_str("H");
    send_buffer();
    push_byte(8'hFF);
    send_buffer();
    // longest phrase that fits, then one byte over the limit
    put_line(1'b1, 200, 255);
    send_buffer();
    put_line(1'b0, 503, 256);
    send_buffer();
    // second line in the same buffer gives nothing
    put_line(1'b1, 301, 2);
    put_line(1'b0, 302, 2);
    send_buffer();
  endtask

  task automatic run_random();
    int sel;
    int at;
    int cut;
    bit held;
    held = 1'b0;
    while (items_sent < StimBytes) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else begin
        put_line(1'($urandom_range(0, 1)), pick_code(), pick_len());
        if ($urandom_range(0, 1) != 0)
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        if ($urandom_range(0, 99) < 25) begin
          at = $urandom_range(0, line_bytes.size() - 1);
          line_bytes[at] = 8'($urandom);
        end
        if ($urandom_range(0, 99) < 12) begin
          cut = $urandom_range(1, line_bytes.size());
          while (line_bytes.size() > cut) void'(line_bytes.pop_back());
        end
      end
      // one long receiver hold-off while bytes keep coming
      if (!held && items_sent >= StimBytes / 3) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      send_buffer();
    end
  endtask

  initial begin : stimulus
    int total;
    model = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    total = 0;
    foreach (model.seen[i]) total += model.seen[i];
    $display("Sent %0d bytes in %0d buffers, with bursty input and one long output stall.",
             items_sent, buffers);
    $display("Checked %0d results: ok %0d, version %0d, separator %0d, code %0d, %s",
             total, model.seen[OutcomeOk], model.seen[OutcomeBadVer],
             model.seen[OutcomeBadSep], model.seen[OutcomeBadCode],
             $sformatf("phrase/CRLF %0d, truncated %0d, too long %0d",
                       model.seen[OutcomeBadPhrase], model.seen[OutcomeTrunc],
                       model.seen[OutcomeTooLong]));
    if (model.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
